FILE: rtl/core/assert_macros.svh
// assertion macros shared by the queue manager rtl
// no dependencies; each file that asserts includes this header
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on a named clock, disabled while the named reset is low
`define ASSERT_AT(lbl, clk_sig, rstn_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) else $error(msg);

// property checked on the module's clk and rst_n
`define ASSERT_STD(lbl, prop, msg) \
    `ASSERT_AT(lbl, clk, rst_n, prop, msg)

`endif

FILE: rtl/core/mqll_pkg.sv
// types and codes of the multi-queue linked-list manager
// no dependencies; used by the controller, datapath and top level
package mqll_pkg;

    // process numbers fill the 6-bit field, the next code up is the null link
    localparam int NUM_PROCS  = 64;
    // ready, blocked, io
    localparam int NUM_QUEUES = 3;

    typedef enum logic [1:0] {
        FUNC_ENQUEUE  = 2'd0,
        FUNC_POP_HEAD = 2'd1,
        FUNC_POP_TAIL = 2'd2,
        FUNC_REMOVE   = 2'd3
    } func_t;

    // one command word
    typedef struct packed {
        func_t       func;
        logic [1:0]  queue_sel;
        logic [5:0]  proc_id;
    } in_word_t;

    // one response word
    typedef struct packed {
        logic        out_valid;
        logic [5:0]  out_proc;
        logic        all_empty;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic write2;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_write2;
    } dp_status_t;

endpackage

FILE: rtl/core/mqll_stream_if.sv
// valid/ready channel carrying one word of a given payload type
// depends on nothing; payload types come from mqll_pkg at the point of use
interface mqll_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/mqll_controller.sv
// sequencer of the queue manager: accept, execute, second write-back, respond
// depends on mqll_pkg and assert_macros.svh
`include "assert_macros.svh"

module mqll_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  mqll_pkg::dp_status_t   status,
    output mqll_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXEC   = 4'b0010,
        ST_WRITE2 = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.capture  = in_valid && (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.need_write2)
                begin
                    state_next = ST_WRITE2;
                end
                else if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_WRITE2:
            begin
                cmd.write2 = 1'b1;
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_STD(a_load_into_free_slot, cmd.load_out |-> out_free,
        "response loaded over an untaken word")
    `ASSERT_STD(a_capture_then_exec, cmd.capture |=> (state_reg == ST_EXEC),
        "accepted word not executed next cycle")
    `ASSERT_STD(a_write2_after_exec,
        (state_reg == ST_WRITE2) |-> ($past(state_reg) == ST_EXEC),
        "second write-back without a preceding execute")

endmodule

FILE: rtl/core/mqll_datapath.sv
// head/tail registers, next/prev link memories and the list update logic
// depends on mqll_pkg and assert_macros.svh
`include "assert_macros.svh"

module mqll_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mqll_pkg::in_word_t     word,
    input  mqll_pkg::ctrl_cmd_t    cmd,
    output mqll_pkg::dp_status_t   status,
    output mqll_pkg::out_word_t    result
);

    localparam int NUM_PROCS  = mqll_pkg::NUM_PROCS;
    localparam int NUM_QUEUES = mqll_pkg::NUM_QUEUES;
    localparam int PTR_W  = $clog2(NUM_PROCS + 1);
    localparam int IDX_W  = $clog2(NUM_PROCS);
    localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NUM_PROCS);

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [IDX_W-1:0] idx_t;

    function automatic logic is_proc(input ptr_t x);
        return x < NULL_PTR;
    endfunction

    // queue ends
    ptr_t head_reg [NUM_QUEUES];
    ptr_t head_next [NUM_QUEUES];
    ptr_t tail_reg [NUM_QUEUES];
    ptr_t tail_next [NUM_QUEUES];

    // link memories
    ptr_t next_mem [NUM_PROCS];
    ptr_t prev_mem [NUM_PROCS];
    ptr_t rd_next_reg;
    ptr_t rd_prev_reg;

    // captured command
    mqll_pkg::func_t func_reg;
    logic            q_ok_reg;
    logic [QIDX_W-1:0] q_idx_reg;
    ptr_t            p_reg;
    logic            p_ok_reg;

    // deferred second write pair
    logic w2n_en_reg;
    idx_t w2n_addr_reg;
    ptr_t w2n_data_reg;
    logic w2p_en_reg;
    idx_t w2p_addr_reg;
    ptr_t w2p_data_reg;

    // response held across write-back and stall
    logic       res_valid_reg;
    logic [5:0] res_proc_reg;
    mqll_pkg::out_word_t result_reg;

    // capture side
    logic              q_ok_in;
    logic              p_ok_in;
    logic [QIDX_W-1:0] q_idx_in;
    ptr_t              p_in;
    ptr_t              head_in;
    ptr_t              tail_in;
    ptr_t              rdn_ptr;
    ptr_t              rdp_ptr;
    idx_t              rdn_addr;
    idx_t              rdp_addr;

    // execute side
    ptr_t h_cur;
    ptr_t t_cur;
    ptr_t h_new;
    ptr_t t_new;
    ptr_t n_lnk;
    ptr_t pr_lnk;
    logic ex_ok;
    logic wn_en;
    idx_t wn_addr;
    ptr_t wn_data;
    logic wp_en;
    idx_t wp_addr;
    ptr_t wp_data;
    logic w2n_en;
    idx_t w2n_addr;
    ptr_t w2n_data;
    logic w2p_en;
    idx_t w2p_addr;
    ptr_t w2p_data;
    logic valid_c;
    ptr_t got_c;

    // memory write ports
    logic mn_we;
    idx_t mn_addr;
    ptr_t mn_data;
    logic mp_we;
    idx_t mp_addr;
    ptr_t mp_data;

    logic all_empty_c;
    logic ends_mismatch;

    // read addresses chosen at capture, data registered for execute
    always_comb
    begin
        q_ok_in  = int'(word.queue_sel) < NUM_QUEUES;
        p_ok_in  = int'(word.proc_id) < NUM_PROCS;
        q_idx_in = QIDX_W'(word.queue_sel);
        p_in     = PTR_W'(word.proc_id);
        head_in  = q_ok_in ? head_reg[q_idx_in] : NULL_PTR;
        tail_in  = q_ok_in ? tail_reg[q_idx_in] : NULL_PTR;
        rdn_ptr  = (word.func == mqll_pkg::FUNC_POP_HEAD) ? head_in : p_in;
        rdp_ptr  = (word.func == mqll_pkg::FUNC_POP_TAIL) ? tail_in : p_in;
        if (word.func == mqll_pkg::FUNC_POP_HEAD)
        begin
            rdn_addr = is_proc(rdn_ptr) ? rdn_ptr[IDX_W-1:0] : '0;
        end
        else
        begin
            rdn_addr = p_ok_in ? rdn_ptr[IDX_W-1:0] : '0;
        end
        if (word.func == mqll_pkg::FUNC_POP_TAIL)
        begin
            rdp_addr = is_proc(rdp_ptr) ? rdp_ptr[IDX_W-1:0] : '0;
        end
        else
        begin
            rdp_addr = p_ok_in ? rdp_ptr[IDX_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg    <= word.func;
            q_ok_reg    <= q_ok_in;
            q_idx_reg   <= q_idx_in;
            p_reg       <= p_in;
            p_ok_reg    <= p_ok_in;
            rd_next_reg <= next_mem[rdn_addr];
            rd_prev_reg <= prev_mem[rdp_addr];
        end
    end

    // list update for the captured command
    always_comb
    begin
        h_cur    = q_ok_reg ? head_reg[q_idx_reg] : NULL_PTR;
        t_cur    = q_ok_reg ? tail_reg[q_idx_reg] : NULL_PTR;
        h_new    = h_cur;
        t_new    = t_cur;
        n_lnk    = is_proc(rd_next_reg) ? rd_next_reg : NULL_PTR;
        pr_lnk   = is_proc(rd_prev_reg) ? rd_prev_reg : NULL_PTR;
        ex_ok    = 1'b0;
        wn_en    = 1'b0;
        wn_addr  = '0;
        wn_data  = NULL_PTR;
        wp_en    = 1'b0;
        wp_addr  = '0;
        wp_data  = NULL_PTR;
        w2n_en   = 1'b0;
        w2n_addr = '0;
        w2n_data = NULL_PTR;
        w2p_en   = 1'b0;
        w2p_addr = '0;
        w2p_data = NULL_PTR;
        valid_c  = 1'b0;
        got_c    = '0;
        case (func_reg)
            mqll_pkg::FUNC_ENQUEUE:
            begin
                if (q_ok_reg && p_ok_reg)
                begin
                    ex_ok   = 1'b1;
                    wn_en   = 1'b1;
                    wn_addr = p_reg[IDX_W-1:0];
                    wp_en   = 1'b1;
                    wp_addr = p_reg[IDX_W-1:0];
                    t_new   = p_reg;
                    if (is_proc(t_cur))
                    begin
                        wp_data  = t_cur;
                        w2n_en   = 1'b1;
                        w2n_addr = t_cur[IDX_W-1:0];
                        w2n_data = p_reg;
                    end
                    else
                    begin
                        h_new = p_reg;
                    end
                end
            end
            mqll_pkg::FUNC_POP_HEAD:
            begin
                if (q_ok_reg && is_proc(h_cur))
                begin
                    ex_ok   = 1'b1;
                    valid_c = 1'b1;
                    got_c   = h_cur;
                    wn_en   = 1'b1;
                    wn_addr = h_cur[IDX_W-1:0];
                    if (is_proc(n_lnk))
                    begin
                        h_new   = n_lnk;
                        wp_en   = 1'b1;
                        wp_addr = n_lnk[IDX_W-1:0];
                    end
                    else
                    begin
                        h_new = NULL_PTR;
                        t_new = NULL_PTR;
                    end
                end
            end
            mqll_pkg::FUNC_POP_TAIL:
            begin
                if (q_ok_reg && is_proc(t_cur))
                begin
                    ex_ok   = 1'b1;
                    valid_c = 1'b1;
                    got_c   = t_cur;
                    wp_en   = 1'b1;
                    wp_addr = t_cur[IDX_W-1:0];
                    if (is_proc(pr_lnk))
                    begin
                        t_new   = pr_lnk;
                        wn_en   = 1'b1;
                        wn_addr = pr_lnk[IDX_W-1:0];
                    end
                    else
                    begin
                        h_new = NULL_PTR;
                        t_new = NULL_PTR;
                    end
                end
            end
            mqll_pkg::FUNC_REMOVE:
            begin
                if (q_ok_reg && p_ok_reg)
                begin
                    ex_ok = 1'b1;
                    if (h_cur == p_reg)
                    begin
                        h_new = n_lnk;
                    end
                    else if (is_proc(pr_lnk))
                    begin
                        wn_en   = 1'b1;
                        wn_addr = pr_lnk[IDX_W-1:0];
                        wn_data = n_lnk;
                    end
                    if (t_cur == p_reg)
                    begin
                        t_new = pr_lnk;
                    end
                    else if (is_proc(n_lnk))
                    begin
                        wp_en   = 1'b1;
                        wp_addr = n_lnk[IDX_W-1:0];
                        wp_data = pr_lnk;
                    end
                    // a null at either end empties the queue
                    if (!is_proc(h_new) || !is_proc(t_new))
                    begin
                        h_new = NULL_PTR;
                        t_new = NULL_PTR;
                    end
                    // removed entry's own links cleared last
                    w2n_en   = 1'b1;
                    w2n_addr = p_reg[IDX_W-1:0];
                    w2p_en   = 1'b1;
                    w2p_addr = p_reg[IDX_W-1:0];
                end
            end
            default:
            begin
                ex_ok = 1'b0;
            end
        endcase
    end

    assign status.need_write2 = w2n_en || w2p_en;

    always_comb
    begin
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            if (cmd.exec && ex_ok && (q_idx_reg == QIDX_W'(i)))
            begin
                head_next[i] = h_new;
                tail_next[i] = t_new;
            end
            else
            begin
                head_next[i] = head_reg[i];
                tail_next[i] = tail_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= NULL_PTR;
                tail_reg[i] <= NULL_PTR;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
            end
        end
    end

    // one write port per memory, first pair at execute, second pair after
    always_comb
    begin
        if (cmd.exec)
        begin
            mn_we   = wn_en;
            mn_addr = wn_addr;
            mn_data = wn_data;
            mp_we   = wp_en;
            mp_addr = wp_addr;
            mp_data = wp_data;
        end
        else
        begin
            mn_we   = cmd.write2 && w2n_en_reg;
            mn_addr = w2n_addr_reg;
            mn_data = w2n_data_reg;
            mp_we   = cmd.write2 && w2p_en_reg;
            mp_addr = w2p_addr_reg;
            mp_data = w2p_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mn_we)
        begin
            next_mem[mn_addr] <= mn_data;
        end
        if (mp_we)
        begin
            prev_mem[mp_addr] <= mp_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            w2n_en_reg    <= w2n_en;
            w2n_addr_reg  <= w2n_addr;
            w2n_data_reg  <= w2n_data;
            w2p_en_reg    <= w2p_en;
            w2p_addr_reg  <= w2p_addr;
            w2p_data_reg  <= w2p_data;
            res_valid_reg <= valid_c;
            res_proc_reg  <= 6'(got_c);
        end
    end

    // response word
    always_comb
    begin
        all_empty_c = 1'b1;
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            if (is_proc(head_next[i]))
            begin
                all_empty_c = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            result_reg.out_valid <= cmd.exec ? valid_c : res_valid_reg;
            result_reg.out_proc  <= cmd.exec ? 6'(got_c) : res_proc_reg;
            result_reg.all_empty <= all_empty_c;
        end
    end

    assign result = result_reg;

    always_comb
    begin
        ends_mismatch = 1'b0;
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            if (is_proc(head_reg[i]) != is_proc(tail_reg[i]))
            begin
                ends_mismatch = 1'b1;
            end
        end
    end

    `ASSERT_STD(a_ends_agree, !ends_mismatch,
        "queue head and tail disagree on emptiness")
    `ASSERT_STD(a_write2_follows_need,
        cmd.write2 |-> ($past(cmd.exec) && $past(status.need_write2)),
        "second write-back without a pending pair")

endmodule

FILE: rtl/core/multi_queue_linked_list_manager.sv
// top level of the multi-queue linked-list manager
// depends on mqll_pkg, mqll_stream_if, mqll_controller and mqll_datapath
//
// keeps NUM_QUEUES fifo queues of process numbers as doubly linked lists
// over next/prev link memories of NUM_PROCS entries, plus a head and tail
// register per queue
// cmd channel: one word per operation (enqueue at tail, pop head, pop tail,
//   remove a named process) on the queue given by queue_sel
// rsp channel: exactly one word per command, with the popped process and
//   its valid flag, and whether every queue is empty afterwards
// sequence: a command is executed in the cycle after it is taken (link
//   memory data read at capture, first write-back pair and end update at
//   execute); enqueue onto a non-empty queue and remove then write the
//   second write-back pair in a separate state, as each link memory has
//   one write port; the response is loaded into the output register at
//   the end of that work
// the output register lets the next command be accepted while a response
//   still waits; when rsp is stalled and a new command finishes, the block
//   holds that response and accepts nothing until the old word is taken
// reset: all queues empty; link memories hold nothing until written and
//   need no clearing pass, the block is ready right after reset
module multi_queue_linked_list_manager (
    input logic          clk,
    input logic          rst_n,
    mqll_stream_if.sink   cmd,
    mqll_stream_if.source rsp
);

    mqll_pkg::ctrl_cmd_t  ctrl;
    mqll_pkg::dp_status_t status;

    // sequencer: capture, execute, optional second write-back, respond
    mqll_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (ctrl)
    );

    // list state, link memories and response register
    mqll_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .word   (cmd.payload),
        .cmd    (ctrl),
        .status (status),
        .result (rsp.payload)
    );

endmodule
